// File: rtl/bitmap_frame_allocator_unit_macros.svh
// assertion helpers for the checker file
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define BFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int ADDR_W = 32;
    localparam int WORD_W = 64;
    localparam int BIT_AW = 6;

    localparam logic [WORD_W-1:0] FULL_WORD = '1;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2
    } t_action;

endpackage

// File: rtl/bfa_req_if.sv
interface bfa_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [bfa_pkg::ADDR_W-1:0]  frame_address;

    modport source (output valid, output action, output frame_address, input ready);
    modport sink   (input valid, input action, input frame_address, output ready);
endinterface

// File: rtl/bfa_rsp_if.sv
interface bfa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::ADDR_W-1:0]  result_address;
    logic                        ok;

    modport source (output valid, output result_address, output ok, input ready);
    modport sink   (input valid, input result_address, input ok, output ready);
endinterface

// File: rtl/bitmap_frame_allocator_unit.sv
// Page frame allocator over a bitmap, one bit per frame, 1 = used.
// i_req carries action (allocate, free, reserve) and a frame byte address;
// o_rsp returns one transfer per request: result_address and ok.
// The bitmap sits in one memory of 64-bit words with a registered read.
// After reset a clearing pass writes all ceil(NUM_FRAMES/64) words (1024
// at the defaults) to all ones; i_req.ready stays low meanwhile.
// Free and reserve: read, modify, write one word, through DECODE, MODIFY
// and DONE; o_rsp.valid is set on leaving DONE, and the next request is
// taken once the block is back in IDLE.
// Allocate scans words one per cycle from a hint (lowest word that may
// hold a free frame) up to the last word, then answers through DONE;
// when the hint says no word may hold a free frame it skips the scan
// and goes from DECODE straight to DONE.
// Out-of-range frames and unused action codes skip to DONE, ok=0.
// The response sits in an output register; a new request is taken while
// it waits, and the block holds in its final state until the register
// frees when o_rsp.ready stays low.
module bitmap_frame_allocator_unit #(
    parameter int NUM_FRAMES = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfa_req_if.sink    i_req,
    bfa_rsp_if.source  o_rsp
);
    import bfa_pkg::*;

    localparam int WORDS      = (NUM_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int HINT_W     = $clog2(WORDS + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FRAME_W    = WORD_AW + BIT_AW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_MODIFY,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [WORD_AW-1:0]  r_clr, n_clr;
    logic [HINT_W-1:0]   r_hint, n_hint;
    logic [WORD_AW-1:0]  r_scan, n_scan;
    logic [1:0]          r_action, n_action;
    logic [WORD_AW-1:0]  r_word, n_word;
    logic [BIT_AW-1:0]   r_bit, n_bit;
    logic                r_in_range, n_in_range;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_res_ok, n_res_ok;
    logic                r_rsp_valid, n_rsp_valid;
    logic [ADDR_W-1:0]   r_rsp_addr, n_rsp_addr;
    logic                r_rsp_ok, n_rsp_ok;

    logic                wr_en;
    logic [WORD_AW-1:0]  wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                rd_en;
    logic [WORD_AW-1:0]  rd_addr;
    logic [WORD_W-1:0]   rd_data;

    logic                find_ok;
    logic [BIT_AW-1:0]   find_idx;

    logic [ADDR_W-1:0]   in_frame;
    logic                req_fire;
    logic [WORD_W-1:0]   bit_mask;
    logic [63:0]         alloc_full;

    bfa_bitmap_ram #(
        .DEPTH (WORDS),
        .AW    (WORD_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bfa_bit_find u_find (
        .i_word  (rd_data),
        .o_found (find_ok),
        .o_index (find_idx)
    );

    assign in_frame   = i_req.frame_address >> PAGE_SHIFT;
    assign req_fire   = i_req.valid && i_req.ready;
    assign bit_mask   = WORD_W'(1) << r_bit;
    assign alloc_full = 64'({r_scan, find_idx}) << PAGE_SHIFT;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hint      = r_hint;
        n_scan      = r_scan;
        n_action    = r_action;
        n_word      = r_word;
        n_bit       = r_bit;
        n_in_range  = r_in_range;
        n_res_addr  = r_res_addr;
        n_res_ok    = r_res_ok;
        n_rsp_valid = r_rsp_valid;
        n_rsp_addr  = r_rsp_addr;
        n_rsp_ok    = r_rsp_ok;
        wr_en       = 1'b0;
        wr_addr     = r_word;
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = r_word;

        if (o_rsp.valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = FULL_WORD;
                if (r_clr == WORD_AW'(WORDS - 1)) begin
                    n_hint  = HINT_W'(WORDS);
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (req_fire) begin
                    n_action   = i_req.action;
                    n_word     = in_frame[FRAME_W-1:BIT_AW];
                    n_bit      = in_frame[BIT_AW-1:0];
                    n_in_range = in_frame < ADDR_W'(NUM_FRAMES);
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_res_addr = '0;
                n_res_ok   = 1'b0;
                case (t_action'(r_action))
                    ACT_ALLOC: begin
                        if (r_hint == HINT_W'(WORDS)) begin
                            n_state = ST_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_hint[WORD_AW-1:0];
                            n_scan  = r_hint[WORD_AW-1:0];
                            n_state = ST_SCAN;
                        end
                    end
                    ACT_FREE, ACT_RESERVE: begin
                        if (r_in_range) begin
                            rd_en   = 1'b1;
                            rd_addr = r_word;
                            n_state = ST_MODIFY;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_MODIFY: begin
                wr_en   = 1'b1;
                wr_addr = r_word;
                if (r_action == ACT_FREE) begin
                    wr_data = rd_data & ~bit_mask;
                    if (HINT_W'(r_word) < r_hint) begin
                        n_hint = HINT_W'(r_word);
                    end
                end else begin
                    wr_data = rd_data | bit_mask;
                end
                n_res_ok = 1'b1;
                n_state  = ST_DONE;
            end
            ST_SCAN: begin
                if (find_ok) begin
                    wr_en      = 1'b1;
                    wr_addr    = r_scan;
                    wr_data    = rd_data | (WORD_W'(1) << find_idx);
                    n_res_addr = alloc_full[ADDR_W-1:0];
                    n_res_ok   = 1'b1;
                    n_hint     = HINT_W'(r_scan);
                    n_state    = ST_DONE;
                end else if (r_scan == WORD_AW'(WORDS - 1)) begin
                    n_hint  = HINT_W'(WORDS);
                    n_state = ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_scan + 1'b1;
                    n_scan  = r_scan + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid = 1'b1;
                    n_rsp_addr  = r_res_addr;
                    n_rsp_ok    = r_res_ok;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_action   <= n_action;
        r_word     <= n_word;
        r_bit      <= n_bit;
        r_in_range <= n_in_range;
        r_res_addr <= n_res_addr;
        r_res_ok   <= n_res_ok;
        r_rsp_addr <= n_rsp_addr;
        r_rsp_ok   <= n_rsp_ok;
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_hint      <= HINT_W'(WORDS);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign i_req.ready          = (r_state == ST_IDLE);
    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.result_address = r_rsp_addr;
    assign o_rsp.ok             = r_rsp_ok;

endmodule

// File: rtl/bfa_bitmap_ram.sv
module bfa_bitmap_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [bfa_pkg::WORD_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [bfa_pkg::WORD_W-1:0]  o_rd_data
);
    import bfa_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/bfa_bit_find.sv
module bfa_bit_find (
    input  logic [bfa_pkg::WORD_W-1:0]  i_word,
    output logic                        o_found,
    output logic [bfa_pkg::BIT_AW-1:0]  o_index
);
    import bfa_pkg::*;

    // lowest clear bit
    always_comb begin
        o_index = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_index = BIT_AW'(i);
            end
        end
    end

    assign o_found = ~&i_word;

endmodule

// File: rtl/bfa_checker.sv
`include "bitmap_frame_allocator_unit_macros.svh"

module bfa_checker #(
    parameter int PAGE_BYTES = 4096
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [bfa_pkg::ADDR_W-1:0]  i_rsp_addr,
    input logic                        i_rsp_ok
);
    import bfa_pkg::*;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

    // stalled response holds
    `BFA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_addr) && $stable(i_rsp_ok), "response changed while stalled")

    // failed request answers address zero
    `BFA_ASSERT_NOW(a_fail_zero, i_rsp_valid && !i_rsp_ok, i_rsp_addr == '0, "failed response with nonzero address")

    // every address returned is page aligned
    `BFA_ASSERT_NOW(a_page_align, i_rsp_valid, (i_rsp_addr & PAGE_MASK) == '0, "response address not page aligned")

    // one request in flight at a time
    `BFA_ASSERT_NEXT(a_busy_after_req, i_req_valid && i_req_ready, !i_req_ready, "request taken while busy")

endmodule

bind bitmap_frame_allocator_unit bfa_checker #(
    .PAGE_BYTES (PAGE_BYTES)
) u_bfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_addr  (o_rsp.result_address),
    .i_rsp_ok    (o_rsp.ok)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bfa_pkg::*;

    localparam int NUM_FRAMES = 65536;
    localparam int PAGE_BYTES = 4096;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int DIR_ROWS = 24;
    localparam int PHASE_ITEMS = 535;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              ok;
    } t_frame_rsp;

    typedef struct packed {
        logic [1:0]        act;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        logic [ADDR_W-1:0] want_addr;
        logic              want_ok;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bfa_req_if req_ch();
    bfa_rsp_if rsp_ch();

    bitmap_frame_allocator_unit #(
        .NUM_FRAMES(NUM_FRAMES),
        .PAGE_BYTES(PAGE_BYTES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // own copy of the frame map: 1 = used
    bit          frame_used [NUM_FRAMES];
    int unsigned free_frames;
    int unsigned lowest_maybe_free;

    t_frame_rsp awaited_outcomes [$];
    int         mismatch_cnt;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_left;
    t_dir_row   steer_rows [DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #120ms;
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        if (mismatch_cnt < 100)
            $display("%0t ns mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic void clear_frame_map();
        foreach (frame_used[f]) frame_used[f] = 1'b1;
        free_frames = 0;
        lowest_maybe_free = NUM_FRAMES;
    endfunction

    // first fit: lowest free frame, else out of memory
    function automatic t_frame_rsp frame_op_outcome(input logic [1:0] act,
                                                    input logic [ADDR_W-1:0] addr);
        t_frame_rsp  r;
        int unsigned f;
        r = '0;
        case (act)
            ACT_ALLOC: begin
                if (free_frames != 0) begin
                    f = lowest_maybe_free;
                    while (frame_used[f]) f++;
                    frame_used[f] = 1'b1;
                    free_frames--;
                    lowest_maybe_free = f + 1;
                    r.addr = ADDR_W'(f * PAGE_BYTES);
                    r.ok = 1'b1;
                end
            end
            ACT_FREE, ACT_RESERVE: begin
                f = addr / PAGE_BYTES;
                if (f < NUM_FRAMES) begin
                    if (act == ACT_FREE && frame_used[f]) begin
                        frame_used[f] = 1'b0;
                        free_frames++;
                        if (f < lowest_maybe_free) lowest_maybe_free = f;
                    end else if (act == ACT_RESERVE && !frame_used[f]) begin
                        frame_used[f] = 1'b1;
                        free_frames--;
                    end
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // returns at the rising edge of the transfer, valid still high
    task automatic send_req(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                            input bit typed, input t_frame_rsp typed_val);
        t_frame_rsp outcome;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.frame_address <= addr;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        outcome = frame_op_outcome(act, addr);
        awaited_outcomes.push_back(typed ? typed_val : outcome);
    endtask

    task automatic quiet_until_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] addr_in_frame(input int unsigned f);
        return ADDR_W'(f * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1));
    endfunction

    task automatic pick_random_req(input int unsigned window, output logic [1:0] act,
                                   output logic [ADDR_W-1:0] addr);
        int unsigned roll;
        roll = $urandom_range(99);
        addr = $urandom();
        if (roll < 30) begin
            act = ACT_ALLOC;
        end else if (roll < 65) begin
            act = ACT_FREE;
            addr = addr_in_frame($urandom_range(window - 1));
        end else if (roll < 80) begin
            act = ACT_RESERVE;
            addr = addr_in_frame($urandom_range(window - 1));
        end else if (roll < 85) begin
            act = $urandom_range(1) ? ACT_FREE : ACT_RESERVE;
            addr = addr_in_frame($urandom_range(NUM_FRAMES - 1));
        end else if (roll < 89) begin
            act = ACT_FREE;
            addr = addr_in_frame($urandom_range(NUM_FRAMES - 1, NUM_FRAMES - 64));
        end else if (roll < 95) begin
            // mostly beyond the last frame
            act = $urandom_range(1) ? ACT_FREE : ACT_RESERVE;
        end else begin
            act = ACT_UNUSED;
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_outcomes.size() == 0) begin
                log_mismatch("response transfer with nothing outstanding");
            end else begin
                want = awaited_outcomes.pop_front();
                if (rsp_ch.result_address !== want.addr)
                    log_mismatch($sformatf("result_address %h, want %h",
                                           rsp_ch.result_address, want.addr));
                if (rsp_ch.ok !== want.ok)
                    log_mismatch($sformatf("ok %b, want %b", rsp_ch.ok, want.ok));
            end
        end
    end

    initial begin
        logic [1:0]        act;
        logic [ADDR_W-1:0] addr;
        int unsigned       window;

        mismatch_cnt = 0;
        hold_left = 0;
        send_idle_pct = 10;
        recv_idle_pct = 63;
        clear_frame_map();
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.action <= ACT_ALLOC;
        req_ch.frame_address <= '0;

        steer_rows = '{
            '{ACT_ALLOC,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{ACT_FREE,    32'h0000_0FFF, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_ALLOC,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_ALLOC,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{ACT_FREE,    32'h0FFF_F000, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_FREE,    32'h0FFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_ALLOC,   32'h0000_0000, 1'b1, 32'h0FFF_F000, 1'b1},
            '{ACT_FREE,    32'h1000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{ACT_RESERVE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
            '{ACT_RESERVE, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_FREE,    32'h0000_1234, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_FREE,    32'h0000_2000, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_RESERVE, 32'h0000_1FFF, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
            '{ACT_UNUSED,  32'h0000_5000, 1'b1, 32'h0000_0000, 1'b0},
            '{ACT_UNUSED,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
            '{ACT_FREE,    32'h0004_0000, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_FREE,    32'h0003_F000, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
            '{ACT_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
            '{ACT_ALLOC,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{ACT_FREE,    32'h0AAA_A555, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_FREE,    32'h0555_5AAA, 1'b1, 32'h0000_0000, 1'b1},
            '{ACT_ALLOC,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steer_rows[i])
            send_req(steer_rows[i].act, steer_rows[i].addr, steer_rows[i].typed,
                     '{steer_rows[i].want_addr, steer_rows[i].want_ok});

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 10 : 0;
            // a narrow window runs the pool dry often
            window = (ph == 1) ? 40 : 512;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 150)
                    hold_left = LONG_HOLD;
                if (ph == 1 && n == 200)
                    quiet_until_drained();
                pick_random_req(window, act, addr);
                send_req(act, addr, 1'b0, '0);
            end
        end

        quiet_until_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_req_if.sv
rtl/bfa_rsp_if.sv
rtl/bfa_bitmap_ram.sv
rtl/bfa_bit_find.sv
rtl/bitmap_frame_allocator_unit.sv
rtl/bfa_checker.sv
bench/tb_top.sv
